[rtl/core/tspa_pkg.sv]
// ----------------------------------------------------------------------------
// tspa_pkg
// Shared types and constants for the timed slot pool allocator.
// ----------------------------------------------------------------------------
package tspa_pkg;

	localparam int POOL_SLOTS_DEF = 16;
	localparam int STEPS_DEF      = 3;

	localparam int TPF_W    = 8;
	localparam int SEL_W    = 4;
	localparam int POS_W    = 16;
	localparam int STEP_W   = 2;
	localparam int STEP_SAT = 3;

	localparam logic [TPF_W-1:0] TPF_RESET = 8'd4;

	localparam logic [1:0] REQ_SPAWN = 2'd0;
	localparam logic [1:0] REQ_TICK  = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	// request token walking the cell chain, with the read answer it collects
	typedef struct packed {
		logic                    valid;
		logic [1:0]              op;
		logic [SEL_W-1:0]        sel;
		logic                    armed;
		logic                    claimed;
		logic                    cand_seen;
		logic                    active;
		logic [STEP_W-1:0]       step;
		logic                    kind;
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
	} probe_t;

	typedef struct packed {
		logic                    kind;
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
	} pay_t;

	typedef struct packed {
		logic claim;
		logic cand;
	} stat_t;

endpackage

[rtl/core/tspa_cell.sv]
// ----------------------------------------------------------------------------
// tspa_cell
// One pool slot. Handles the request token passing through it and hands the
// token to the next cell on the following cycle.
// ----------------------------------------------------------------------------
module tspa_cell #(
	parameter int IDX            = 0,
	parameter int STEPS_PER_ANIM = tspa_pkg::STEPS_DEF,
	parameter int AGE_W          = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tspa_pkg::probe_t   probe_in,
	output tspa_pkg::probe_t   probe_out,
	input  logic               mark,
	input  logic               commit,
	input  tspa_pkg::pay_t     pay,
	input  logic [AGE_W-1:0]   limit,
	input  logic [AGE_W-1:0]   thr [tspa_pkg::STEP_SAT],
	output tspa_pkg::stat_t    stat
);
	import tspa_pkg::*;

	localparam int MAXK = (STEPS_PER_ANIM - 1 < STEP_SAT) ? STEPS_PER_ANIM - 1 : STEP_SAT;

	logic                    active_q;
	logic                    cand_q;
	logic [AGE_W-1:0]        age_q;
	logic                    kind_q;
	logic signed [POS_W-1:0] x_q;
	logic signed [POS_W-1:0] y_q;
	probe_t                  probe_q;

	logic              elig;
	logic              spawn;
	logic              tick;
	logic              claim_now;
	logic              cand_now;
	logic              take;
	logic [AGE_W-1:0]  age_inc;
	logic [STEP_W-1:0] step;
	probe_t            p_nx;

	always_comb begin
		elig      = probe_in.armed | mark;
		spawn     = probe_in.valid && (probe_in.op == REQ_SPAWN);
		tick      = probe_in.valid && (probe_in.op == REQ_TICK);
		claim_now = spawn && elig && !probe_in.claimed && !active_q;
		cand_now  = spawn && !elig && !probe_in.cand_seen && !active_q;
		take      = claim_now || (commit && cand_q);
		age_inc   = age_q + 1'b1;

		step = '0;
		for (int k = 0; k < STEP_SAT; k++) begin
			if (k < MAXK && age_q >= thr[k]) begin
				step = step + 1'b1;
			end
		end

		p_nx           = probe_in;
		p_nx.armed     = elig;
		p_nx.claimed   = probe_in.claimed | claim_now;
		p_nx.cand_seen = probe_in.cand_seen | cand_now;
		if (probe_in.valid && probe_in.op == REQ_READ && int'(probe_in.sel) == IDX) begin
			p_nx.active = active_q;
			if (active_q) begin
				p_nx.step = step;
				p_nx.kind = kind_q;
				p_nx.x    = x_q;
				p_nx.y    = y_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cand_q   <= 1'b0;
			probe_q  <= '0;
		end else begin
			probe_q <= p_nx;
			if (spawn) begin
				cand_q <= cand_now;
			end
			if (take) begin
				active_q <= 1'b1;
			end else if (tick && active_q && age_inc >= limit) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			age_q  <= '0;
			kind_q <= pay.kind;
			x_q    <= pay.x;
			y_q    <= pay.y;
		end else if (tick && active_q) begin
			age_q <= age_inc;
		end
	end

	assign probe_out  = probe_q;
	assign stat.claim = claim_now;
	assign stat.cand  = cand_now;

endmodule

[rtl/core/timed_slot_pool_allocator.sv]
// ----------------------------------------------------------------------------
// timed_slot_pool_allocator
// The request token walks one cell per cycle. done rises together with the
// registered results once the token has left the last cell; a new request
// can be taken in the cycle done is high, but not while busy.
// Reset: all slots free, seek pointer 0, ticks_per_frame 4. Results cannot
// be stalled by the receiver.
// ----------------------------------------------------------------------------
module timed_slot_pool_allocator #(
	parameter int POOL_SLOTS     = tspa_pkg::POOL_SLOTS_DEF,
	parameter int STEPS_PER_ANIM = tspa_pkg::STEPS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	output logic                              done,
	input  logic                              cfg_we,
	input  logic [tspa_pkg::TPF_W-1:0]        cfg_wdata,
	input  logic [1:0]                        req_type,
	input  logic                              kind,
	input  logic signed [tspa_pkg::POS_W-1:0] pos_x,
	input  logic signed [tspa_pkg::POS_W-1:0] pos_y,
	input  logic [tspa_pkg::SEL_W-1:0]        slot_sel,
	output logic                              granted,
	output logic [tspa_pkg::SEL_W-1:0]        slot_out,
	output logic                              pool_full,
	output logic                              active,
	output logic [tspa_pkg::STEP_W-1:0]       anim_step,
	output logic                              kind_out,
	output logic signed [tspa_pkg::POS_W-1:0] x_out,
	output logic signed [tspa_pkg::POS_W-1:0] y_out
);
	import tspa_pkg::*;

	localparam int IDX_W = $clog2(POOL_SLOTS);
	localparam int AGE_W = $clog2(STEPS_PER_ANIM * 255 + 2);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_SLOTS - 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_LAP  = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t             state_q;
	logic [TPF_W-1:0]   tpf_q;
	logic [IDX_W-1:0]   ptr_q;
	logic [IDX_W-1:0]   cnt_q;
	logic [IDX_W-1:0]   claim_idx_q;
	logic [IDX_W-1:0]   cand_idx_q;
	probe_t             inj_q;
	pay_t               pay_q;
	logic               done_q;

	logic                    granted_q;
	logic [SEL_W-1:0]        slot_q;
	logic                    full_q;
	logic                    active_q;
	logic [STEP_W-1:0]       step_q;
	logic                    kind_q;
	logic signed [POS_W-1:0] x_q;
	logic signed [POS_W-1:0] y_q;

	probe_t            chain [POOL_SLOTS+1];
	stat_t             st [POOL_SLOTS];
	logic [POOL_SLOTS-1:0] mark_v;
	logic [TPF_W-1:0]  ftk;
	logic [AGE_W-1:0]  limit;
	logic [AGE_W-1:0]  thr [STEP_SAT];
	logic              any_claim;
	logic              any_cand;
	logic              accept;
	logic              commit;
	probe_t            lp;
	probe_t            inj_d;

	logic                    r_granted;
	logic [SEL_W-1:0]        r_slot;
	logic                    r_full;
	logic                    r_ptr_upd;
	logic [IDX_W-1:0]        r_ptr;
	logic                    r_commit;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign lp     = chain[POOL_SLOTS];
	assign commit = (state_q == ST_FIN) && r_commit;

	always_comb begin
		ftk   = (tpf_q == '0) ? TPF_W'(1) : tpf_q;
		limit = AGE_W'(int'(ftk) * STEPS_PER_ANIM);
		for (int k = 0; k < STEP_SAT; k++) begin
			thr[k] = AGE_W'(int'(ftk) * (k + 1));
		end
	end

	always_comb begin
		inj_d = '0;
		if (accept) begin
			inj_d.valid = 1'b1;
			inj_d.op    = req_type;
			inj_d.sel   = slot_sel;
		end
	end

	assign chain[0] = inj_q;

	for (genvar i = 0; i < POOL_SLOTS; i++) begin : g_cell
		assign mark_v[i] = (ptr_q == IDX_W'(i));

		tspa_cell #(
			.IDX            (i),
			.STEPS_PER_ANIM (STEPS_PER_ANIM),
			.AGE_W          (AGE_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.probe_in  (chain[i]),
			.probe_out (chain[i+1]),
			.mark      (mark_v[i]),
			.commit    (commit),
			.pay       (pay_q),
			.limit     (limit),
			.thr       (thr),
			.stat      (st[i])
		);
	end

	always_comb begin
		any_claim = 1'b0;
		any_cand  = 1'b0;
		for (int i = 0; i < POOL_SLOTS; i++) begin
			any_claim = any_claim | st[i].claim;
			any_cand  = any_cand | st[i].cand;
		end
	end

	// final decision once the token leaves the last cell
	always_comb begin
		r_granted = 1'b0;
		r_slot    = '0;
		r_full    = 1'b0;
		r_ptr_upd = 1'b0;
		r_ptr     = '0;
		r_commit  = 1'b0;
		unique case (lp.op)
			REQ_SPAWN: begin
				if (lp.claimed) begin
					r_granted = 1'b1;
					r_slot    = SEL_W'(claim_idx_q);
					r_ptr_upd = 1'b1;
					r_ptr     = (claim_idx_q == LAST_IDX) ? '0 : claim_idx_q + 1'b1;
				end else if (lp.cand_seen) begin
					r_granted = 1'b1;
					r_commit  = 1'b1;
					r_slot    = SEL_W'(cand_idx_q);
					r_ptr_upd = 1'b1;
					r_ptr     = (cand_idx_q == LAST_IDX) ? '0 : cand_idx_q + 1'b1;
				end else begin
					r_full = 1'b1;
				end
			end
			REQ_READ: begin
				r_slot = lp.sel;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tpf_q   <= TPF_RESET;
			ptr_q   <= '0;
			cnt_q   <= '0;
			inj_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				tpf_q <= cfg_wdata;
			end
			inj_q  <= inj_d;
			done_q <= (state_q == ST_FIN);
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						cnt_q   <= '0;
						state_q <= ST_LAP;
					end
				end
				ST_LAP: begin
					if (cnt_q == LAST_IDX) begin
						state_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FIN: begin
					if (r_ptr_upd) begin
						ptr_q <= r_ptr;
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pay_q.kind <= kind;
			pay_q.x    <= pos_x;
			pay_q.y    <= pos_y;
		end
		if (state_q == ST_LAP && any_claim) begin
			claim_idx_q <= cnt_q;
		end
		if (state_q == ST_LAP && any_cand) begin
			cand_idx_q <= cnt_q;
		end
		if (state_q == ST_FIN) begin
			granted_q <= r_granted;
			slot_q    <= r_slot;
			full_q    <= r_full;
			active_q  <= lp.active;
			step_q    <= lp.step;
			kind_q    <= lp.kind;
			x_q       <= lp.x;
			y_q       <= lp.y;
		end
	end

	assign granted   = granted_q;
	assign slot_out  = slot_q;
	assign pool_full = full_q;
	assign active    = active_q;
	assign anim_step = step_q;
	assign kind_out  = kind_q;
	assign x_out     = x_q;
	assign y_out     = y_q;

endmodule
